### design/tdc_pkg.sv
package tdc_pkg;

   localparam int SeqLen = 28;
   localparam logic [4:0] LastIdx = 5'(SeqLen - 1);
   localparam logic [7:0] EscChar = 8'd27;
   localparam logic [7:0] SpaceChar = 8'h20;

   typedef enum logic [1:0] {
      FUNC_SET  = 2'd0,
      FUNC_STOP = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   // One job for the back end: a display of the time as BCD digits, or a clear.
   typedef struct packed {
      logic       disp;
      logic [1:0] ht;
      logic [3:0] ho;
      logic [2:0] mt;
      logic [3:0] mo;
      logic [2:0] st;
      logic [3:0] so;
   } job_type;

   function automatic logic [7:0] ascii_digit(input logic [3:0] d);
      return {4'h3, d};
   endfunction

   function automatic logic [7:0] byte_of(input job_type j, input logic [4:0] i);
      logic [7:0] b;
      b = SpaceChar;
      case (i)
         5'd0, 5'd3, 5'd24: b = EscChar;
         5'd1, 5'd4, 5'd25: b = 8'h5B;
         5'd2:  b = 8'h73;
         5'd5:  b = 8'h30;
         5'd6:  b = 8'h3B;
         5'd7, 5'd8: b = 8'h36;
         5'd9:  b = 8'h48;
         5'd26: b = 8'h75;
         5'd27: b = 8'h00;
         5'd10: b = j.disp ? 8'h54 : SpaceChar;
         5'd11: b = j.disp ? 8'h69 : SpaceChar;
         5'd12: b = j.disp ? 8'h6D : SpaceChar;
         5'd13: b = j.disp ? 8'h65 : SpaceChar;
         5'd14, 5'd18, 5'd21: b = j.disp ? 8'h3A : SpaceChar;
         5'd15: b = SpaceChar;
         5'd16: b = j.disp ? ascii_digit({2'b00, j.ht}) : SpaceChar;
         5'd17: b = j.disp ? ascii_digit(j.ho) : SpaceChar;
         5'd19: b = j.disp ? ascii_digit({1'b0, j.mt}) : SpaceChar;
         5'd20: b = j.disp ? ascii_digit(j.mo) : SpaceChar;
         5'd22: b = j.disp ? ascii_digit({1'b0, j.st}) : SpaceChar;
         5'd23: b = j.disp ? ascii_digit(j.so) : SpaceChar;
         default: b = SpaceChar;
      endcase
      return b;
   endfunction

endpackage

### design/time_of_day_clock_display_top.sv
// Path: with the output side idle, an accepted displaying item is written into the job queue,
// and the back end then registers its first beat in its output register before it is offered.
// Throughput: one byte per cycle while rsp_stall is low; each display or clear item sends 28
// beats, so the output serializer sets the sustained rate of display and clear items.
// A two-entry job queue lets items that send nothing pass at one per cycle while it has room.
// Reset (synchronous, active high) stops the clock, zeroes the time, empties the queue.
module time_of_day_clock_display_top
   import tdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_hour_tens_char,
   input  logic [7:0] req_hour_ones_char,
   input  logic [7:0] req_first_sep_char,
   input  logic [7:0] req_min_tens_char,
   input  logic [7:0] req_min_ones_char,
   input  logic [7:0] req_second_sep_char,
   input  logic [7:0] req_sec_tens_char,
   input  logic [7:0] req_sec_ones_char,
   input  logic       req_string_ended,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [0:0] rsp_last_byte
);

   logic    q_full, q_not_empty, push, pop;
   job_type push_job, q_head;

   tdc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_hour_tens_char  (req_hour_tens_char),
      .req_hour_ones_char  (req_hour_ones_char),
      .req_first_sep_char  (req_first_sep_char),
      .req_min_tens_char   (req_min_tens_char),
      .req_min_ones_char   (req_min_ones_char),
      .req_second_sep_char (req_second_sep_char),
      .req_sec_tens_char   (req_sec_tens_char),
      .req_sec_ones_char   (req_sec_ones_char),
      .req_string_ended    (req_string_ended),
      .q_full              (q_full),
      .push                (push),
      .push_job            (push_job)
   );

   tdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   tdc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

### design/tdc_front.sv
module tdc_front
   import tdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_hour_tens_char,
   input  logic [7:0] req_hour_ones_char,
   input  logic [7:0] req_first_sep_char,
   input  logic [7:0] req_min_tens_char,
   input  logic [7:0] req_min_ones_char,
   input  logic [7:0] req_second_sep_char,
   input  logic [7:0] req_sec_tens_char,
   input  logic [7:0] req_sec_ones_char,
   input  logic       req_string_ended,
   input  logic       q_full,
   output logic       push,
   output job_type    push_job
);

   logic    running_ff, running_in;
   job_type time_ff, time_in;
   job_type set_time, tick_time;
   logic    set_ok, accept;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      set_time      = '0;
      set_time.disp = 1'b1;
      set_time.ht   = req_hour_tens_char[1:0];
      set_time.ho   = req_hour_ones_char[3:0];
      set_time.mt   = req_min_tens_char[2:0];
      set_time.mo   = req_min_ones_char[3:0];
      set_time.st   = req_sec_tens_char[2:0];
      set_time.so   = req_sec_ones_char[3:0];
      set_ok = (req_first_sep_char == 8'h3A) && (req_second_sep_char == 8'h3A) &&
               req_string_ended &&
               is_digit(req_hour_tens_char) && is_digit(req_hour_ones_char) &&
               is_digit(req_min_tens_char) && is_digit(req_min_ones_char) &&
               is_digit(req_sec_tens_char) && is_digit(req_sec_ones_char) &&
               ((req_hour_tens_char[3:0] <= 4'd1) ||
                (req_hour_tens_char[3:0] == 4'd2 && req_hour_ones_char[3:0] <= 4'd3)) &&
               (req_min_tens_char[3:0] <= 4'd5) && (req_sec_tens_char[3:0] <= 4'd5);
   end

   // BCD advance by one second, wrap at end of day
   always_comb begin
      tick_time      = time_ff;
      tick_time.disp = 1'b1;
      if (time_ff.so != 4'd9) begin
         tick_time.so = time_ff.so + 4'd1;
      end else begin
         tick_time.so = 4'd0;
         if (time_ff.st != 3'd5) begin
            tick_time.st = time_ff.st + 3'd1;
         end else begin
            tick_time.st = 3'd0;
            if (time_ff.mo != 4'd9) begin
               tick_time.mo = time_ff.mo + 4'd1;
            end else begin
               tick_time.mo = 4'd0;
               if (time_ff.mt != 3'd5) begin
                  tick_time.mt = time_ff.mt + 3'd1;
               end else begin
                  tick_time.mt = 3'd0;
                  if (time_ff.ht == 2'd2 && time_ff.ho == 4'd3) begin
                     tick_time.ht = 2'd0;
                     tick_time.ho = 4'd0;
                  end else if (time_ff.ho == 4'd9) begin
                     tick_time.ho = 4'd0;
                     tick_time.ht = time_ff.ht + 2'd1;
                  end else begin
                     tick_time.ho = time_ff.ho + 4'd1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      running_in = running_ff;
      time_in    = time_ff;
      push       = 1'b0;
      push_job   = '0;
      if (accept) begin
         case (func_type'(req_func))
            FUNC_SET: begin
               if (set_ok) begin
                  time_in    = set_time;
                  running_in = 1'b1;
                  push       = 1'b1;
                  push_job   = set_time;
               end else if (running_ff) begin
                  running_in = 1'b0;
                  push       = 1'b1;
               end
            end
            FUNC_STOP: begin
               running_in = 1'b0;
               push       = 1'b1;
            end
            FUNC_TICK: begin
               if (running_ff) begin
                  time_in  = tick_time;
                  push     = 1'b1;
                  push_job = tick_time;
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         time_ff    <= '0;
      end else begin
         running_ff <= running_in;
         time_ff    <= time_in;
      end
   end

endmodule

### design/tdc_queue.sv
module tdc_queue
   import tdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);

   job_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff ^ push;
      rd_in    = rd_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/tdc_back.sv
module tdc_back
   import tdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  job_type    q_head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [0:0] rsp_last_byte
);

   logic       busy_ff, busy_in;
   logic [4:0] idx_ff, idx_in;
   job_type    job_ff, job_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       advance;
   job_type    sel_job;
   logic [4:0] sel_idx;

   assign advance = !valid_ff || !rsp_stall;
   assign pop     = advance && !busy_ff && q_not_empty;
   assign sel_job = busy_ff ? job_ff : q_head;
   assign sel_idx = busy_ff ? idx_ff : 5'd0;

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      job_in   = job_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         if (busy_ff || q_not_empty) begin
            // emit next beat of the current sequence, or the first of a new one
            job_in   = sel_job;
            valid_in = 1'b1;
            byte_in  = byte_of(sel_job, sel_idx);
            last_in  = (sel_idx == LastIdx);
            idx_in   = sel_idx + 5'd1;
            busy_in  = (sel_idx != LastIdx);
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

### design/tdc_checker.sv
module tdc_checker
   import tdc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [0:0] rsp_last_byte
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte))
      else $error("stalled result beat changed");

   a_last_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_byte[0] |-> rsp_out_byte == 8'h00)
      else $error("last beat is not the terminating zero");

   a_next_starts_with_esc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_byte[0] |=> !rsp_valid || rsp_out_byte == EscChar)
      else $error("sequence does not open with escape");

endmodule

bind time_of_day_clock_display_top tdc_checker u_tdc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);

### bench/tb_time_of_day_clock_display_top.sv
`timescale 1ns / 1ps

module tb_time_of_day_clock_display_top;
   import tdc_pkg::*;

   localparam logic [1:0] FuncUnused = 2'd3;
   localparam int QuietLimit = 3000;
   localparam int ItemsPerPhase = 50;

   typedef struct packed {
      logic       ended;
      logic [7:0][7:0] chars;   // chars[0] is the hour tens character
      logic [1:0] func;
   } clock_item_t;

   class clock_display_scoreboard;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       running;
      logic [8:0] display_beats[$];   // {last_byte, out_byte}
      int         errors;

      function new();
         hours = '0;
         minutes = '0;
         seconds = '0;
         running = 1'b0;
         errors = 0;
      endfunction

      function int pending();
         return display_beats.size();
      endfunction

      function void push_sequence(bit show_time);
         string text;
         string line;
         int    i;
         text = show_time ? $sformatf("Time: %02d:%02d:%02d", hours, minutes, seconds)
                          : $sformatf("%14s", "");
         line = {$sformatf("%c[s%c[0;66H", EscChar, EscChar), text,
                 $sformatf("%c[u", EscChar)};
         for (i = 0; i < line.len(); i++)
            display_beats.push_back({1'b0, line[i]});
         display_beats.push_back({1'b1, 8'h00});
      endfunction

      function int note_item(clock_item_t it);
         bit ok;
         int i;
         int h;
         ok = it.ended && it.chars[2] == ":" && it.chars[5] == ":";
         for (i = 0; i < 8; i++)
            if (i != 2 && i != 5 && (it.chars[i] < "0" || it.chars[i] > "9"))
               ok = 1'b0;
         h = (it.chars[0] - 8'h30) * 10 + (it.chars[1] - 8'h30);
         case (it.func)
            FUNC_SET: begin
               if (ok && h <= 23 && it.chars[3] <= "5" && it.chars[6] <= "5") begin
                  hours = 5'(h);
                  minutes = 6'((it.chars[3] - 8'h30) * 10 + (it.chars[4] - 8'h30));
                  seconds = 6'((it.chars[6] - 8'h30) * 10 + (it.chars[7] - 8'h30));
                  running = 1'b1;
                  push_sequence(1'b1);
                  return SeqLen;
               end else if (running) begin
                  running = 1'b0;
                  push_sequence(1'b0);
                  return SeqLen;
               end
               return 0;
            end
            FUNC_STOP: begin
               running = 1'b0;
               push_sequence(1'b0);
               return SeqLen;
            end
            FUNC_TICK: begin
               if (!running)
                  return 0;
               seconds++;
               if (seconds >= 6'd60) begin
                  seconds = '0;
                  minutes++;
                  if (minutes >= 6'd60) begin
                     minutes = '0;
                     hours++;
                     if (hours >= 5'd24)
                        hours = '0;
                  end
               end
               push_sequence(1'b1);
               return SeqLen;
            end
            default: return 0;
         endcase
      endfunction

      function void check_beat(logic [7:0] got_byte, logic got_last);
         logic [8:0] want;
         if (display_beats.size() == 0) begin
            $error("beat with none expected: out_byte %h last_byte %b", got_byte, got_last);
            errors++;
         end else begin
            want = display_beats.pop_front();
            if (got_byte !== want[7:0]) begin
               $error("out_byte expected %h actual %h", want[7:0], got_byte);
               errors++;
            end
            if (got_last !== want[8]) begin
               $error("last_byte expected %b actual %b", want[8], got_last);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   clock_item_t req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [0:0]  rsp_last_byte;

   int send_idle_pct = 37;
   int rsp_stall_pct = 80;
   int quiet_cycles = 0;

   clock_display_scoreboard board = new();

   time_of_day_clock_display_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_item.func),
      .req_hour_tens_char  (req_item.chars[0]),
      .req_hour_ones_char  (req_item.chars[1]),
      .req_first_sep_char  (req_item.chars[2]),
      .req_min_tens_char   (req_item.chars[3]),
      .req_min_ones_char   (req_item.chars[4]),
      .req_second_sep_char (req_item.chars[5]),
      .req_sec_tens_char   (req_item.chars[6]),
      .req_sec_ones_char   (req_item.chars[7]),
      .req_string_ended    (req_item.ended),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last_byte       (rsp_last_byte)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall)
            void'(board.note_item(req_item));
         if (rsp_valid && !rsp_stall)
            board.check_beat(rsp_out_byte, rsp_last_byte[0]);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QuietLimit)
         @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic clock_item_t clock_time(int h, int m, int s);
      clock_item_t it;
      it.func = FUNC_SET;
      it.ended = 1'b1;
      it.chars[0] = 8'(8'h30 + (h / 10) % 10);
      it.chars[1] = 8'(8'h30 + h % 10);
      it.chars[2] = ":";
      it.chars[3] = 8'(8'h30 + (m / 10) % 10);
      it.chars[4] = 8'(8'h30 + m % 10);
      it.chars[5] = ":";
      it.chars[6] = 8'(8'h30 + (s / 10) % 10);
      it.chars[7] = 8'(8'h30 + s % 10);
      return it;
   endfunction

   // Characters do not matter here; fill them so every bit toggles.
   function automatic clock_item_t filler(logic [1:0] func);
      clock_item_t it;
      it = clock_item_t'({$urandom, $urandom, 3'($urandom)});
      it.func = func;
      return it;
   endfunction

   function automatic clock_item_t random_time();
      int h;
      int m;
      int s;
      if ($urandom_range(1)) begin
         h = $urandom_range(23);
         m = $urandom_range(59);
         s = $urandom_range(59);
      end else begin
         // land near a carry so following ticks roll minutes, hours and the day
         h = $urandom_range(1) ? 23 : $urandom_range(23);
         m = $urandom_range(1) ? 59 : $urandom_range(59);
         s = $urandom_range(55, 59);
      end
      return clock_time(h, m, s);
   endfunction

   function automatic clock_item_t broken_time();
      clock_item_t it;
      int          pos;
      logic [7:0]  b;
      it = random_time();
      case ($urandom_range(4))
         0: begin
            pos = $urandom_range(7);
            if (pos == 2 || pos == 5)
               pos = pos + 1;
            do b = 8'($urandom_range(255)); while (b >= "0" && b <= "9");
            it.chars[pos] = b;
         end
         1: begin
            if ($urandom_range(1)) begin
               it.chars[0] = "2";
               it.chars[1] = 8'(8'h34 + $urandom_range(5));
            end else begin
               it.chars[0] = 8'(8'h33 + $urandom_range(6));
            end
         end
         2: it.chars[$urandom_range(1) ? 3 : 6] = 8'(8'h36 + $urandom_range(3));
         3: begin
            do b = 8'($urandom_range(255)); while (b == ":");
            it.chars[$urandom_range(1) ? 2 : 5] = b;
         end
         default: it.ended = 1'b0;
      endcase
      return it;
   endfunction

   task automatic send_item(input clock_item_t it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Hold the sender until every queued display beat has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic run_random(int count);
      int sent;
      int k;
      int n;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            send_item(random_time());
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
               send_item(filler(FUNC_TICK));
            sent = sent + n;
         end else if (pick < 65) begin
            send_item(filler(FUNC_TICK));
         end else if (pick < 75) begin
            send_item(filler(FUNC_STOP));
         end else if (pick < 88) begin
            send_item(broken_time());
         end else begin
            send_item(filler(2'($urandom_range(3))));
         end
         sent++;
      end
   endtask

   initial begin
      clock_item_t it;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // stopped clock: tick, bad set and unused code do nothing; stop still clears
      send_item(filler(FUNC_TICK));
      it = clock_time(12, 0, 0);
      it.ended = 1'b0;
      send_item(it);
      send_item(filler(FUNC_STOP));
      send_item(filler(FuncUnused));
      send_item(clock_time(23, 59, 59));
      send_item(filler(FUNC_TICK));
      send_item(filler(FUNC_TICK));
      send_item(filler(FuncUnused));
      send_item(clock_time(0, 0, 0));
      send_item(clock_time(24, 0, 0));
      send_item(clock_time(9, 59, 59));
      send_item(filler(FUNC_TICK));
      it = clock_time(12, 34, 56);
      it.chars[2] = ";";
      send_item(it);
      send_item(clock_time(0, 59, 59));
      send_item(filler(FUNC_TICK));
      send_item(clock_time(19, 60, 0));
      send_item(clock_time(19, 5, 9));
      send_item(clock_time(19, 0, 60));
      send_item(clock_time(23, 59, 58));
      it = clock_time(1, 2, 3);
      it.chars[7] = "a";
      send_item(it);
      send_item(clock_time(20, 0, 0));
      send_item(filler(FUNC_STOP));
      send_item(filler(FUNC_TICK));
      it = '1;
      it.func = FUNC_SET;
      send_item(it);
      it = '0;
      send_item(it);
      wait_drained();

      run_random(ItemsPerPhase);
      wait_drained();
      send_idle_pct = 80;
      rsp_stall_pct = 37;
      run_random(ItemsPerPhase);
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random(ItemsPerPhase);
      wait_drained();

      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
